// ----- hw/rtl/biq_pkg.sv -----
// ----------------------------------------------------------------------------
// biq_pkg
// Shared types and constants for the high-shelf biquad filter: coefficient
// slot codes, sequencer states and the multiplier control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package biq_pkg;

  localparam int COEF_W    = 32;
  localparam int NUM_COEFS = 6;
  localparam int CFG_IDX_W = 3;
  localparam int BIT_CNT_W = $clog2(COEF_W);

  // Coefficient slots. The same code selects the register on the
  // configuration port and the product being formed by the sequencer.
  typedef enum logic [CFG_IDX_W-1:0] {
    TAP_FF0  = 3'd0,
    TAP_FF1  = 3'd1,
    TAP_FF2  = 3'd2,
    TAP_FB1  = 3'd3,
    TAP_FB2  = 3'd4,
    TAP_NORM = 3'd5
  } tap_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_ACC
  } state_e;

  typedef struct packed {
    logic load;  // start a product: clear partial sum, take both operands
    logic step;  // consume one multiplier bit
    logic msb;   // the bit being consumed is the sign bit
  } mul_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/biq_coef_regs.sv -----
// ----------------------------------------------------------------------------
// biq_coef_regs
// The six Q-format coefficient registers with their write port, and the
// select that hands one of them to the serial multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module biq_coef_regs
  import biq_pkg::*;
#(
  parameter int COEF_FRAC_BITS = 24
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [COEF_W-1:0]    cfg_wdata_i,
  input  wire tap_e                 sel_i,
  output logic      [COEF_W-1:0]    coef_o
);

  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC_BITS;

  logic [COEF_W-1:0] ff0_q, ff1_q, ff2_q, fb1_q, fb2_q, norm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ff0_q  <= COEF_ONE;
      ff1_q  <= '0;
      ff2_q  <= '0;
      fb1_q  <= '0;
      fb2_q  <= '0;
      norm_q <= COEF_ONE;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        TAP_FF0:  ff0_q  <= cfg_wdata_i;
        TAP_FF1:  ff1_q  <= cfg_wdata_i;
        TAP_FF2:  ff2_q  <= cfg_wdata_i;
        TAP_FB1:  fb1_q  <= cfg_wdata_i;
        TAP_FB2:  fb2_q  <= cfg_wdata_i;
        TAP_NORM: norm_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel_i)
      TAP_FF0:  coef_o = ff0_q;
      TAP_FF1:  coef_o = ff1_q;
      TAP_FF2:  coef_o = ff2_q;
      TAP_FB1:  coef_o = fb1_q;
      TAP_FB2:  coef_o = fb2_q;
      TAP_NORM: coef_o = norm_q;
      default:  coef_o = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/biq_serial_mul.sv -----
// ----------------------------------------------------------------------------
// biq_serial_mul
// Bit-serial signed multiplier. The coefficient sits in a shift register and
// is consumed one bit per cycle while step is asserted, LSB first; the partial
// sum shifts right and its low bits fill the coefficient register from the top.
// ----------------------------------------------------------------------------
`default_nettype none

module biq_serial_mul
  import biq_pkg::*;
#(
  parameter int A_W = 59
) (
  input  wire logic                    clk_i,
  input  wire mul_ctrl_t               ctrl_i,
  input  wire logic [A_W-1:0]          a_i,
  input  wire logic [COEF_W-1:0]       b_i,
  output logic      [A_W+COEF_W-1:0]   prod_o
);

  logic [A_W-1:0]    a_q;
  logic [A_W:0]      part_q, part_d;
  logic [COEF_W-1:0] low_q, low_d;
  logic [A_W+1:0]    a_ext, addend, sum;

  // The sign bit of the coefficient carries negative weight, so the last
  // step subtracts the multiplicand instead of adding it.
  always_comb begin
    a_ext = {{2{a_q[A_W-1]}}, a_q};
    if (!low_q[0]) begin
      addend = '0;
    end else if (ctrl_i.msb) begin
      addend = -a_ext;
    end else begin
      addend = a_ext;
    end
    sum    = {part_q[A_W], part_q} + addend;
    part_d = sum[A_W+1:1];
    low_d  = {sum[0], low_q[COEF_W-1:1]};
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      a_q    <= a_i;
      part_q <= '0;
      low_q  <= b_i;
    end else if (ctrl_i.step) begin
      part_q <= part_d;
      low_q  <= low_d;
    end
  end

  assign prod_o = {part_q[A_W-1:0], low_q};

endmodule

`default_nettype wire

// ----- hw/rtl/biq_round_sat.sv -----
// ----------------------------------------------------------------------------
// biq_round_sat
// Final scaling of the normalized product: round half up at the binary
// point, then clamp to the sample range and flag the clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module biq_round_sat #(
  parameter int SAMPLE_WIDTH   = 24,
  parameter int COEF_FRAC_BITS = 24,
  parameter int PROD_W         = 91
) (
  input  wire logic [PROD_W-1:0]       prod_i,
  output logic      [SAMPLE_WIDTH-1:0] filtered_o,
  output logic                         clipped_o
);

  localparam int SHIFT = 2 * COEF_FRAC_BITS;
  localparam int Q_W   = PROD_W - SHIFT;

  logic [Q_W-1:0] quot;
  logic [Q_W:0]   rounded;
  logic [Q_W:0]   top_bits;
  logic           fits;

  always_comb begin
    quot     = prod_i[PROD_W-1:SHIFT];
    rounded  = {quot[Q_W-1], quot} + {{Q_W{1'b0}}, prod_i[SHIFT-1]};
    // The value fits when every bit from the sample sign bit upward agrees.
    top_bits = rounded >> (SAMPLE_WIDTH - 1);
    fits     = (top_bits == '0) ||
               (top_bits == ({(Q_W+1){1'b1}} >> (SAMPLE_WIDTH - 1)));
    if (fits) begin
      filtered_o = rounded[SAMPLE_WIDTH-1:0];
      clipped_o  = 1'b0;
    end else if (rounded[Q_W]) begin
      filtered_o = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      clipped_o  = 1'b1;
    end else begin
      filtered_o = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      clipped_o  = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/high_shelf_biquad_filter.sv -----
// ----------------------------------------------------------------------------
// high_shelf_biquad_filter
// Direct form I biquad with a final normalizing gain. All six products are
// formed one after another on a single bit-serial multiplier.
//
//   channel  direction  handshake                  payload
//   in       to block   in_valid_i / in_stall_o     sample_i
//   out      from block out_valid_o / out_stall_i   filtered_o, clipped_o
//   cfg      to block   cfg_we_i                    cfg_index_i, cfg_wdata_i
//
// A sample is taken in the idle state; each of the six products then passes
// through a load state, one shift per coefficient bit and an accumulate state.
// Reset clears the sample and output history and loads unity gain into the
// first forward (FF0) and the normalizing coefficients. The result sits in an
// output register; a stalled output only holds the sequencer at its final step.
// ----------------------------------------------------------------------------
`default_nettype none

module high_shelf_biquad_filter
  import biq_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = 24,
  parameter int COEF_FRAC_BITS = 24
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [SAMPLE_WIDTH-1:0] sample_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic      [SAMPLE_WIDTH-1:0] filtered_o,
  output logic                         clipped_o,
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [COEF_W-1:0]       cfg_wdata_i
);

  // Five sample-by-coefficient products and their sum fit with room to spare.
  localparam int ACC_W  = SAMPLE_WIDTH + 35;
  localparam int PROD_W = ACC_W + COEF_W;
  localparam int EXT_W  = ACC_W - SAMPLE_WIDTH;
  localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(COEF_W - 1);

  state_e                  state_q, state_d;
  tap_e                    tap_q, tap_d;
  logic [BIT_CNT_W-1:0]    cnt_q, cnt_d;
  logic [ACC_W-1:0]        acc_q, acc_d;
  logic [SAMPLE_WIDTH-1:0] x0_q, x0_d, x1_q, x1_d, x2_q, x2_d;
  logic [SAMPLE_WIDTH-1:0] y1_q, y1_d, y2_q, y2_d;
  logic [SAMPLE_WIDTH-1:0] filtered_q, filtered_d;
  logic                    clipped_q, clipped_d;
  logic                    out_valid_q, out_valid_d;

  mul_ctrl_t               mul_ctrl;
  logic [ACC_W-1:0]        operand;
  logic [COEF_W-1:0]       coef;
  logic [PROD_W-1:0]       prod;
  logic [SAMPLE_WIDTH-1:0] rs_filtered;
  logic                    rs_clipped;
  logic                    out_free;

  biq_coef_regs #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_coef_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .sel_i      (tap_q),
    .coef_o     (coef)
  );

  biq_serial_mul #(
    .A_W(ACC_W)
  ) u_serial_mul (
    .clk_i (clk_i),
    .ctrl_i(mul_ctrl),
    .a_i   (operand),
    .b_i   (coef),
    .prod_o(prod)
  );

  biq_round_sat #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .COEF_FRAC_BITS(COEF_FRAC_BITS),
    .PROD_W        (PROD_W)
  ) u_round_sat (
    .prod_i    (prod),
    .filtered_o(rs_filtered),
    .clipped_o (rs_clipped)
  );

  // Multiplicand for the product in progress, sign extended to the
  // accumulator width. The normalizing product takes the whole sum.
  always_comb begin
    case (tap_q)
      TAP_FF0:  operand = {{EXT_W{x0_q[SAMPLE_WIDTH-1]}}, x0_q};
      TAP_FF1:  operand = {{EXT_W{x1_q[SAMPLE_WIDTH-1]}}, x1_q};
      TAP_FF2:  operand = {{EXT_W{x2_q[SAMPLE_WIDTH-1]}}, x2_q};
      TAP_FB1:  operand = {{EXT_W{y1_q[SAMPLE_WIDTH-1]}}, y1_q};
      TAP_FB2:  operand = {{EXT_W{y2_q[SAMPLE_WIDTH-1]}}, y2_q};
      TAP_NORM: operand = acc_q;
      default:  operand = '0;
    endcase
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    tap_d       = tap_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    x0_d        = x0_q;
    x1_d        = x1_q;
    x2_d        = x2_q;
    y1_d        = y1_q;
    y2_d        = y2_q;
    filtered_d  = filtered_q;
    clipped_d   = clipped_q;
    out_valid_d = out_valid_q && out_stall_i;
    mul_ctrl    = '0;
    in_stall_o  = 1'b1;

    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          x0_d    = sample_i;
          tap_d   = TAP_FF0;
          acc_d   = '0;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        mul_ctrl.load = 1'b1;
        cnt_d         = '0;
        state_d       = ST_MUL;
      end
      ST_MUL: begin
        mul_ctrl.step = 1'b1;
        mul_ctrl.msb  = (cnt_q == LAST_BIT);
        cnt_d         = cnt_q + 1'b1;
        if (cnt_q == LAST_BIT) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        case (tap_q)
          TAP_FF0, TAP_FF1, TAP_FF2: begin
            acc_d   = acc_q + prod[ACC_W-1:0];
            tap_d   = tap_e'(tap_q + 1'b1);
            state_d = ST_LOAD;
          end
          TAP_FB1, TAP_FB2: begin
            acc_d   = acc_q - prod[ACC_W-1:0];
            tap_d   = tap_e'(tap_q + 1'b1);
            state_d = ST_LOAD;
          end
          default: begin
            // Normalized product is ready; wait here until the output
            // register can take it, then retire the sample into history.
            if (out_free) begin
              filtered_d  = rs_filtered;
              clipped_d   = rs_clipped;
              out_valid_d = 1'b1;
              x2_d        = x1_q;
              x1_d        = x0_q;
              y2_d        = y1_q;
              y1_d        = rs_filtered;
              state_d     = ST_IDLE;
            end
          end
        endcase
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tap_q       <= TAP_FF0;
      cnt_q       <= '0;
      x1_q        <= '0;
      x2_q        <= '0;
      y1_q        <= '0;
      y2_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tap_q       <= tap_d;
      cnt_q       <= cnt_d;
      x1_q        <= x1_d;
      x2_q        <= x2_d;
      y1_q        <= y1_d;
      y2_q        <= y2_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    x0_q       <= x0_d;
    filtered_q <= filtered_d;
    clipped_q  <= clipped_d;
  end

  assign out_valid_o = out_valid_q;
  assign filtered_o  = filtered_q;
  assign clipped_o   = clipped_q;

endmodule

`default_nettype wire
